// ===== design/frd_pkg.sv =====
`default_nettype none

package frd_pkg;

   localparam int DataWidth = 32;
   localparam int CntWidth  = $clog2(DataWidth);

   localparam logic [DataWidth-1:0] MaxMag = {1'b0, {(DataWidth-1){1'b1}}};

   typedef struct packed {
      logic signed [DataWidth-1:0] numerator;
      logic signed [DataWidth-1:0] denominator;
   } req_type;

   typedef struct packed {
      logic signed [DataWidth-1:0] reduced_numerator;
      logic        [DataWidth-2:0] reduced_denominator;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_GCD_DIV,
      ST_GCD_UPD,
      ST_NUM_DIV,
      ST_DEN_START,
      ST_DEN_DIV,
      ST_DONE
   } state_type;

   typedef enum logic [1:0] {
      SEL_GCD,
      SEL_NUM,
      SEL_DEN
   } div_sel_type;

   typedef struct packed {
      logic        load;
      logic        div_start;
      div_sel_type div_sel;
      logic        div_step;
      logic        gcd_update;
      logic        store_num;
      logic        store_den;
   } cmd_type;

   typedef struct packed {
      logic b_zero;
      logic div_last;
   } status_type;

endpackage

`default_nettype wire

// ===== design/frd_controller.sv =====
`default_nettype none

module frd_controller (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  frd_pkg::status_type     status,
   output frd_pkg::cmd_type        cmd,
   output logic                    busy,
   output logic                    done
);
   import frd_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) state_in = ST_CHECK;
         end
         ST_CHECK: begin
            state_in = status.b_zero ? ST_NUM_DIV : ST_GCD_DIV;
         end
         ST_GCD_DIV: begin
            if (status.div_last) state_in = ST_GCD_UPD;
         end
         ST_GCD_UPD: begin
            state_in = ST_CHECK;
         end
         ST_NUM_DIV: begin
            if (status.div_last) state_in = ST_DEN_START;
         end
         ST_DEN_START: begin
            state_in = ST_DEN_DIV;
         end
         ST_DEN_DIV: begin
            if (status.div_last) state_in = ST_DONE;
         end
         ST_DONE: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd  = '0;
      busy = 1'b1;
      done = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            busy     = 1'b0;
            cmd.load = start;
         end
         ST_CHECK: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = status.b_zero ? SEL_NUM : SEL_GCD;
         end
         ST_GCD_DIV: begin
            cmd.div_step = 1'b1;
         end
         ST_GCD_UPD: begin
            cmd.gcd_update = 1'b1;
         end
         ST_NUM_DIV: begin
            cmd.div_step  = 1'b1;
            cmd.store_num = status.div_last;
         end
         ST_DEN_START: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = SEL_DEN;
         end
         ST_DEN_DIV: begin
            cmd.div_step  = 1'b1;
            cmd.store_den = status.div_last;
         end
         ST_DONE: begin
            done = 1'b1;
         end
         default: begin
            busy = 1'b1;
         end
      endcase
   end

endmodule

`default_nettype wire

// ===== design/frd_datapath.sv =====
`default_nettype none

module frd_datapath (
   input  wire logic               clock,
   input  frd_pkg::req_type        req_data,
   input  frd_pkg::cmd_type        cmd,
   output frd_pkg::status_type     status,
   output frd_pkg::rsp_type        rsp_data
);
   import frd_pkg::*;

   localparam int W = DataWidth;

   // magnitudes fit W bits unsigned, including 2^(W-1)
   logic [W-1:0]        a_ff, a_in;
   logic [W-1:0]        b_ff, b_in;
   logic [W-1:0]        nm_ff, nm_in;
   logic [W-1:0]        dm_ff, dm_in;
   logic                neg_ff, neg_in;
   logic [W-1:0]        rem_ff, rem_in;
   logic [W-1:0]        quo_ff, quo_in;
   logic [W-1:0]        dvs_ff, dvs_in;
   logic [CntWidth-1:0] cnt_ff, cnt_in;
   rsp_type             rsp_ff, rsp_in;

   logic [W-1:0] den_fix;
   logic [W-1:0] num_mag;
   logic [W-1:0] den_mag;
   logic [W:0]   trial;
   logic [W:0]   diff;
   logic         fits;
   logic [W-1:0] q_sat;

   always_comb begin
      den_fix = (req_data.denominator == '0) ? W'(1) : req_data.denominator;
      num_mag = req_data.numerator[W-1] ? (~req_data.numerator + W'(1))
                                        : req_data.numerator;
      den_mag = den_fix[W-1] ? (~den_fix + W'(1)) : den_fix;

      trial = {rem_ff, quo_ff[W-1]};
      diff  = trial - {1'b0, dvs_ff};
      fits  = (trial >= {1'b0, dvs_ff});

      a_in   = a_ff;
      b_in   = b_ff;
      nm_in  = nm_ff;
      dm_in  = dm_ff;
      neg_in = neg_ff;
      rem_in = rem_ff;
      quo_in = quo_ff;
      dvs_in = dvs_ff;
      cnt_in = cnt_ff;
      rsp_in = rsp_ff;

      if (cmd.load) begin
         nm_in  = num_mag;
         dm_in  = den_mag;
         a_in   = num_mag;
         b_in   = den_mag;
         neg_in = req_data.numerator[W-1] ^ den_fix[W-1];
      end

      if (cmd.div_start) begin
         rem_in = '0;
         cnt_in = CntWidth'(W - 1);
         case (cmd.div_sel)
            SEL_NUM: begin
               quo_in = nm_ff;
               dvs_in = a_ff;
            end
            SEL_DEN: begin
               quo_in = dm_ff;
               dvs_in = a_ff;
            end
            default: begin
               quo_in = a_ff;
               dvs_in = b_ff;
            end
         endcase
      end

      if (cmd.div_step) begin
         rem_in = fits ? diff[W-1:0] : trial[W-1:0];
         quo_in = {quo_ff[W-2:0], fits};
         cnt_in = cnt_ff - CntWidth'(1);
      end

      q_sat = quo_in[W-1] ? MaxMag : quo_in;

      if (cmd.gcd_update) begin
         a_in = b_ff;
         b_in = rem_ff;
      end

      if (cmd.store_num) begin
         rsp_in.reduced_numerator = neg_ff ? (~q_sat + W'(1)) : q_sat;
      end

      if (cmd.store_den) begin
         rsp_in.reduced_denominator = q_sat[W-2:0];
      end
   end

   always_ff @(posedge clock) begin
      a_ff   <= a_in;
      b_ff   <= b_in;
      nm_ff  <= nm_in;
      dm_ff  <= dm_in;
      neg_ff <= neg_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
      cnt_ff <= cnt_in;
      rsp_ff <= rsp_in;
   end

   assign status.b_zero   = (b_ff == '0);
   assign status.div_last = (cnt_ff == '0);
   assign rsp_data        = rsp_ff;

endmodule

`default_nettype wire

// ===== design/fraction_reducer.sv =====
// Reduces a signed fraction to lowest terms with a positive denominator; a zero
// denominator counts as one. A fraction is taken when start is high while busy
// is low, and its result appears on rsp_data with rsp_valid high for a single
// cycle; the receiver cannot stall it, so it must take the beat in that cycle.
// One fraction is worked at a time by a shared one-bit-per-cycle restoring
// divider: each Euclid remainder step is one full division followed by an
// update of the operand pair, then the two final divisions by the gcd follow;
// busy falls in the cycle after the result appears.
`default_nettype none

module fraction_reducer (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          start,
   output logic               busy,
   input  frd_pkg::req_type   req_data,
   output logic               rsp_valid,
   output frd_pkg::rsp_type   rsp_data
);
   import frd_pkg::*;

   cmd_type    cmd;
   status_type status;

   frd_controller u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .status (status),
      .cmd    (cmd),
      .busy   (busy),
      .done   (rsp_valid)
   );

   frd_datapath u_dp (
      .clock    (clock),
      .req_data (req_data),
      .cmd      (cmd),
      .status   (status),
      .rsp_data (rsp_data)
   );

endmodule

`default_nettype wire
